// ----- sv/pcmfc_pkg.sv -----
// Shared format codes, widths and types for the PCM sample format converter.
`timescale 1ns / 1ps
`default_nettype none

package pcmfc_pkg;

   localparam int unsigned FmtWidth    = 3;
   localparam int unsigned SampleWidth = 32;

   localparam logic [FmtWidth-1:0] FMT_FLOAT = 3'd0;
   localparam logic [FmtWidth-1:0] FMT_U8    = 3'd1;
   localparam logic [FmtWidth-1:0] FMT_U16LE = 3'd2;
   localparam logic [FmtWidth-1:0] FMT_U16BE = 3'd3;
   localparam logic [FmtWidth-1:0] FMT_S16LE = 3'd4;
   localparam logic [FmtWidth-1:0] FMT_S16BE = 3'd5;

   localparam logic [FmtWidth-1:0] DEST_RESET = FMT_FLOAT;

   // one input beat held between the input register and the datapath
   typedef struct packed {
      logic [FmtWidth-1:0]    src_format;
      logic [SampleWidth-1:0] sample;
   } item_type;

   function automatic logic [15:0] swap16(input logic [15:0] w);
      return {w[7:0], w[15:8]};
   endfunction

endpackage

`default_nettype wire

// ----- sv/pcm_sample_format_converter_core.sv -----
// PCM sample converter top level: input register, datapath, result register, CSR.
//
// Usage:
//   req_* carries one sample per beat: tdata is the raw sample, tuser the source
//   format (0 float32, 1 u8, 2 u16le, 3 u16be, 4 s16le, 5 s16be).
//   rsp_* returns one converted sample per accepted beat, in order.
//   csr_* writes the 3-bit destination format; write only while the block is idle.
//   csr_ready is always high.
// Path: a req beat is taken into the input register, converted by the logic between
//   the input and result registers, and registered in the result register, which
//   drives rsp_tvalid; a low rsp_tready can hold the beat in either register.
// Throughput: one sample per cycle while the output is not stalled, set by the single-pass conversion datapath.
// Reset: both pipeline stages empty, destination format back to float32.
// Stall: a low rsp_tready holds the result; the input register still takes one
//   more beat, then req_tready drops until the result register drains.
`timescale 1ns / 1ps
`default_nettype none

module pcm_sample_format_converter_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [pcmfc_pkg::SampleWidth-1:0]    req_tdata,   // [31:0] sample_in
   input  wire logic [pcmfc_pkg::FmtWidth-1:0]       req_tuser,   // [2:0] src_format
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic      [pcmfc_pkg::SampleWidth-1:0]    rsp_tdata,   // [31:0] sample_out
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [pcmfc_pkg::FmtWidth-1:0]       csr_data
);

   logic [pcmfc_pkg::FmtWidth-1:0]      dest_fmt_ff, dest_fmt_in;
   logic                                s1_valid_ff, s1_valid_in;
   pcmfc_pkg::item_type                 s1_item_ff, s1_item_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [pcmfc_pkg::SampleWidth-1:0]   rsp_data_ff, rsp_data_in;
   logic [pcmfc_pkg::SampleWidth-1:0]   conv_out;
   logic                                advance;

   assign csr_ready  = 1'b1;
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   pcmfc_convert u_convert (
      .item        (s1_item_ff),
      .dest_format (dest_fmt_ff),
      .sample_out  (conv_out)
   );

   always_comb begin
      dest_fmt_in  = csr_valid ? csr_data : dest_fmt_ff;
      s1_valid_in  = req_tready ? req_tvalid : s1_valid_ff;
      s1_item_in   = (req_tvalid && req_tready) ?
                     pcmfc_pkg::item_type'{src_format: req_tuser, sample: req_tdata} :
                     s1_item_ff;
      rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
      rsp_data_in  = (advance && s1_valid_ff) ? conv_out : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_fmt_ff  <= pcmfc_pkg::DEST_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dest_fmt_ff  <= dest_fmt_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTH
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("input taken while both stages are full and stalled");

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> s1_valid_ff)
      else $error("accepted beat did not reach the input register");

   a_stage_moves_to_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && advance |=> rsp_tvalid)
      else $error("converted beat lost between stages");

   a_dest_holds: assert property (@(posedge clock) disable iff (reset)
      !csr_valid |=> $stable(dest_fmt_ff))
      else $error("destination format changed without a write");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !s1_valid_ff)
      else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

// ----- sv/pcmfc_float_to_int.sv -----
// Float32 sample to u8/u16/s16 value with rounding, truncation and saturation.
`timescale 1ns / 1ps
`default_nettype none

module pcmfc_float_to_int (
   input  wire logic [31:0]                      fbits,
   input  wire logic [pcmfc_pkg::FmtWidth-1:0]   dest_format,
   output logic      [15:0]                      value
);

   logic               sgn;
   logic [7:0]         ef;
   logic [23:0]        mant;
   logic signed [10:0] e_unb;
   logic signed [10:0] e_scl;
   logic signed [10:0] amt_s;
   logic [6:0]         amt;
   logic [67:0]        shifted;
   logic [41:0]        mag;          // |v*K| with 25 fraction bits
   logic               sticky;
   logic               big;
   logic               is_u8;
   logic               is_s16;
   logic [43:0]        koff;
   logic [43:0]        term;
   logic [43:0]        ysum;
   logic [17:0]        ipart;
   logic [24:0]        frac;
   logic [4:0]         lp1;
   logic [24:0]        low_mask;
   logic               roundup;
   logic [18:0]        nval;
   logic [16:0]        trunc_mag;
   logic [15:0]        u_res;
   logic [15:0]        s_res;

   assign sgn    = fbits[31];
   assign ef     = fbits[30:23];
   assign mant   = (ef == 8'd0) ? {1'b0, fbits[22:0]} : {1'b1, fbits[22:0]};
   assign is_u8  = (dest_format == pcmfc_pkg::FMT_U8);
   assign is_s16 = (dest_format == pcmfc_pkg::FMT_S16LE) ||
                   (dest_format == pcmfc_pkg::FMT_S16BE);

   assign e_unb = (ef == 8'd0) ? -11'sd126 : ($signed({3'b000, ef}) - 11'sd127);
   assign e_scl = e_unb + (is_u8 ? 11'sd7 : 11'sd15);
   assign big   = (e_scl >= 11'sd17);

   // mantissa lsb sits at 2^(E-23); place it on a grid of 2^-25
   assign amt_s   = 11'sd16 - e_scl;
   assign amt     = (amt_s > 11'sd68) ? 7'd68 :
                    (amt_s < 11'sd0)  ? 7'd0  : amt_s[6:0];
   assign shifted = {mant, 44'b0} >> amt;
   assign mag     = shifted[67:26];
   assign sticky  = |shifted[25:0];

   // unsigned targets: exact floor of (v*K + K) on the 2^-25 grid
   assign koff = is_u8 ? (44'd128 << 25) : (44'd32768 << 25);
   assign term = !sgn   ? {2'b00, mag} :
                 sticky ? ~{2'b00, mag} : (44'd0 - {2'b00, mag});
   assign ysum  = koff + term;
   assign ipart = ysum[42:25];
   assign frac  = ysum[24:0];

   // float32 rounding reaches the next integer when the top fraction bits are all
   // ones; how many depends on the exponent of the sum (ties round up, even grid)
   always_comb begin
      lp1 = 5'd0;
      for (int i = 0; i < 18; i++) begin
         if (ipart[i]) lp1 = 5'(i + 1);
      end
   end

   assign low_mask = (25'd1 << lp1) - 25'd1;
   assign roundup  = &(frac | low_mask);
   assign nval     = {1'b0, ipart} + {18'd0, roundup};

   always_comb begin
      if (big) begin
         u_res = sgn ? 16'd0 : (is_u8 ? 16'd255 : 16'hffff);
      end else if (ysum[43]) begin
         u_res = 16'd0;
      end else if (is_u8) begin
         u_res = (nval >= 19'd255) ? 16'd255 : {8'd0, nval[7:0]};
      end else begin
         u_res = (nval > 19'd65535) ? 16'hffff : nval[15:0];
      end
   end

   // signed target: v*32768 is exact, so only truncate and clamp
   assign trunc_mag = mag[41:25];

   always_comb begin
      if (big) begin
         s_res = sgn ? 16'h8000 : 16'h7fff;
      end else if (!sgn) begin
         s_res = (trunc_mag > 17'd32767) ? 16'h7fff : trunc_mag[15:0];
      end else begin
         s_res = (trunc_mag > 17'd32768) ? 16'h8000 : (16'd0 - trunc_mag[15:0]);
      end
   end

   assign value = is_s16 ? s_res : u_res;

endmodule

`default_nettype wire

// ----- sv/pcmfc_convert.sv -----
// Combinational conversion of one sample from its source format to the destination.
`timescale 1ns / 1ps
`default_nettype none

module pcmfc_convert (
   input  wire pcmfc_pkg::item_type                 item,
   input  wire logic [pcmfc_pkg::FmtWidth-1:0]      dest_format,
   output logic      [pcmfc_pkg::SampleWidth-1:0]   sample_out
);

   logic [15:0] w_le;
   logic [15:0] w_be;
   logic [15:0] x;            // integer sources on a signed 1/32768 scale
   logic        src_float;
   logic        src_nan;
   logic [16:0] xmag;
   logic [4:0]  msb;
   logic [23:0] norm;
   logic [31:0] x_float;
   logic [15:0] f2i_val;
   logic [15:0] int_res;
   logic [15:0] int_wire;

   assign w_le      = item.sample[15:0];
   assign w_be      = pcmfc_pkg::swap16(item.sample[15:0]);
   assign src_float = (item.src_format == pcmfc_pkg::FMT_FLOAT);
   assign src_nan   = (item.sample[30:23] == 8'hff) && (item.sample[22:0] != 23'd0);

   always_comb begin
      case (item.src_format)
         pcmfc_pkg::FMT_U8:    x = {~item.sample[7], item.sample[6:0], 8'd0};
         pcmfc_pkg::FMT_U16LE: x = {~w_le[15], w_le[14:0]};
         pcmfc_pkg::FMT_U16BE: x = {~w_be[15], w_be[14:0]};
         pcmfc_pkg::FMT_S16LE: x = w_le;
         pcmfc_pkg::FMT_S16BE: x = w_be;
         default:              x = 16'd0;
      endcase
   end

   // x / 32768 as float32
   assign xmag = x[15] ? (17'd0 - {1'b1, x}) : {1'b0, x};

   always_comb begin
      msb = 5'd0;
      for (int i = 0; i < 17; i++) begin
         if (xmag[i]) msb = 5'(i);
      end
   end

   assign norm    = {7'd0, xmag} << (5'd23 - msb);
   assign x_float = (xmag == 17'd0) ? 32'd0 :
                    {x[15], 8'(msb) + 8'd112, norm[22:0]};

   pcmfc_float_to_int u_f2i (
      .fbits       (item.sample),
      .dest_format (dest_format),
      .value       (f2i_val)
   );

   always_comb begin
      if (src_float && !src_nan) begin
         int_res = f2i_val;
      end else begin
         case (dest_format)
            pcmfc_pkg::FMT_U8:                       int_res = {8'd0, x[15:8] ^ 8'h80};
            pcmfc_pkg::FMT_U16LE, pcmfc_pkg::FMT_U16BE: int_res = x ^ 16'h8000;
            default:                                 int_res = x;
         endcase
      end
   end

   assign int_wire = ((dest_format == pcmfc_pkg::FMT_U16BE) ||
                      (dest_format == pcmfc_pkg::FMT_S16BE)) ?
                     pcmfc_pkg::swap16(int_res) : int_res;

   always_comb begin
      case (dest_format)
         pcmfc_pkg::FMT_FLOAT: sample_out = src_float ? item.sample : x_float;
         pcmfc_pkg::FMT_U8,
         pcmfc_pkg::FMT_U16LE,
         pcmfc_pkg::FMT_U16BE,
         pcmfc_pkg::FMT_S16LE,
         pcmfc_pkg::FMT_S16BE: sample_out = {16'd0, int_wire};
         default:              sample_out = '0;
      endcase
   end

endmodule

`default_nettype wire
